// ----- rtl/core/scpd_pkg.sv -----
// Shared types and constants of the spectrum peak color driver.
`timescale 1ns / 1ps

package scpd_pkg;

  // Field and datapath widths.
  localparam int BAND_W   = 16;
  localparam int BIDX_W   = 7;
  localparam int CFG_W    = 16;
  localparam int LEVEL_W  = 10;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int RATIO_W  = 17;
  localparam int OFFSET_W = 24;
  localparam int CHAN_W   = 8;
  localparam int PROD_W   = LEVEL_W + RATIO_W;
  localparam int DIV_N_W  = 40;
  localparam int DIV_D_W  = 16;

  // Fixed limits of the color and statistics arithmetic.
  localparam logic [LEVEL_W-1:0]  FULL_LEVEL = 10'd1020;
  localparam logic [RATIO_W-1:0]  RATIO_MIN  = 17'd6554;
  localparam logic [RATIO_W-1:0]  RATIO_ONE  = 17'd65536;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 24'hFF0000;
  localparam logic [SUM_W-1:0]    SUM_MAX    = 24'hFFFFFF;
  localparam logic [CNT_W-1:0]    COUNT_MAX  = 8'hFF;
  localparam logic [BAND_W-1:0]   AVG_MAX    = 16'hFFFF;
  localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'hFF;

  // Register reset values.
  localparam logic [CFG_W-1:0] AMP_LIMIT_RST = 16'd32000;
  localparam logic [CFG_W-1:0] DECAY_RST     = 16'd62915;
  localparam logic [CFG_W-1:0] THRESH_RST    = 16'd640;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_AMP_LIMIT = 2'd0;
  localparam logic [1:0] REG_DECAY     = 2'd1;
  localparam logic [1:0] REG_THRESH    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_ACC,
    ST_WHEEL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_AMP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_OFFSET,
    DIV_AVG
  } div_op_t;

  typedef struct packed {
    logic    clear_wr;
    logic    accept;
    logic    mul;
    logic    upd;
    logic    acc;
    logic    wheel;
    logic    div_start;
    div_op_t div_op;
    logic    div_capture;
    logic    amp_mul;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_band;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/spectrum_peak_color_driver.sv -----
// Top level of the spectrum peak color driver: configuration registers and core.
//
// Input channel (in_valid/in_ready): one word per spectrum band, with band_index,
// band_level (Q4.12) and last_band. A band arriving back to back is taken only once
// the last has passed the band store read, decay multiply and write back.
// A band marked last_band closes the frame: the color wheel steps, then the shared
// one-bit-per-cycle divider runs three 40-step divisions (ratio, offset, average)
// before the next band is taken.
// Output channel (out_valid/out_ready): one word per frame with the amplified
// color and this frame's peak and average. The result sits in an output register,
// so the next frame's bands are taken while it waits; only the next frame end
// waits for a stalled receiver.
// Configuration: APB writes at byte addresses 0 (amplitude_limit), 4 (decay_factor)
// and 8 (useful_threshold); the user makes them only while the block is idle, not
// enforced by the block; pready is always high. Reset (rst, synchronous) restores
// register defaults and the color wheel, then a clearing pass zeroes the band
// store; no band is taken until it ends; configuration writes are taken throughout.
`timescale 1ns / 1ps

module spectrum_peak_color_driver #(
  parameter int MAX_BANDS = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scpd_pkg::BIDX_W-1:0] band_index,
  input  logic [scpd_pkg::BAND_W-1:0] band_level,
  input  logic                        last_band,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scpd_pkg::CHAN_W-1:0] red_out,
  output logic [scpd_pkg::CHAN_W-1:0] green_out,
  output logic [scpd_pkg::CHAN_W-1:0] blue_out,
  output logic [scpd_pkg::BAND_W-1:0] frame_peak_out,
  output logic [scpd_pkg::BAND_W-1:0] frame_average_out
);

  localparam int CFG_W = scpd_pkg::CFG_W;

  logic [CFG_W-1:0]     amplitude_limit;
  logic [CFG_W-1:0]     decay_factor;
  logic [CFG_W-1:0]     useful_threshold;
  logic                 cfg_wr;
  scpd_pkg::dp_cmd_t    cmd;
  scpd_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_limit  <= scpd_pkg::AMP_LIMIT_RST;
      decay_factor     <= scpd_pkg::DECAY_RST;
      useful_threshold <= scpd_pkg::THRESH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        scpd_pkg::REG_AMP_LIMIT: amplitude_limit  <= pwdata[CFG_W-1:0];
        scpd_pkg::REG_DECAY:     decay_factor     <= pwdata[CFG_W-1:0];
        scpd_pkg::REG_THRESH:    useful_threshold <= pwdata[CFG_W-1:0];
        default: begin
          amplitude_limit <= amplitude_limit;
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      scpd_pkg::REG_AMP_LIMIT: prdata = 32'(amplitude_limit);
      scpd_pkg::REG_DECAY:     prdata = 32'(decay_factor);
      scpd_pkg::REG_THRESH:    prdata = 32'(useful_threshold);
      default:                 prdata = '0;
    endcase
  end

  scpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scpd_dp #(
    .MAX_BANDS (MAX_BANDS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .band_index        (band_index),
    .band_level        (band_level),
    .last_band         (last_band),
    .amplitude_limit   (amplitude_limit),
    .decay_factor      (decay_factor),
    .useful_threshold  (useful_threshold),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .red_out           (red_out),
    .green_out         (green_out),
    .blue_out          (blue_out),
    .frame_peak_out    (frame_peak_out),
    .frame_average_out (frame_average_out)
  );

endmodule

// ----- rtl/core/scpd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module scpd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [scpd_pkg::DIV_N_W-1:0] dividend,
  input  logic [scpd_pkg::DIV_D_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [scpd_pkg::DIV_N_W-1:0] quotient
);

  localparam int N_W   = scpd_pkg::DIV_N_W;
  localparam int D_W   = scpd_pkg::DIV_D_W;
  localparam int CNT_B = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   div_r;
  logic [CNT_B-1:0] cnt;
  logic [D_W:0]     trial;
  logic             ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem, quotient[N_W-1]};
    ge    = (trial >= {1'b0, div_r});
  end

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_B'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_B'(N_W);
      end else if (busy) begin
        cnt <= cnt - CNT_B'(1);
        if (cnt == CNT_B'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient registers; the quotient shifts in from the dividend.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div_r    <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? D_W'(trial - {1'b0, div_r}) : trial[D_W-1:0];
      quotient <= {quotient[N_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/scpd_dp.sv -----
// Datapath: band store, frame statistics, color wheel, division and scaling.
`timescale 1ns / 1ps

module scpd_dp #(
  parameter int MAX_BANDS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scpd_pkg::dp_cmd_t             cmd,
  output scpd_pkg::dp_status_t          status,
  input  logic [scpd_pkg::BIDX_W-1:0]   band_index,
  input  logic [scpd_pkg::BAND_W-1:0]   band_level,
  input  logic                          last_band,
  input  logic [scpd_pkg::CFG_W-1:0]    amplitude_limit,
  input  logic [scpd_pkg::CFG_W-1:0]    decay_factor,
  input  logic [scpd_pkg::CFG_W-1:0]    useful_threshold,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scpd_pkg::CHAN_W-1:0]   red_out,
  output logic [scpd_pkg::CHAN_W-1:0]   green_out,
  output logic [scpd_pkg::CHAN_W-1:0]   blue_out,
  output logic [scpd_pkg::BAND_W-1:0]   frame_peak_out,
  output logic [scpd_pkg::BAND_W-1:0]   frame_average_out
);

  localparam int IDX_W    = $clog2(MAX_BANDS);
  localparam int IN_SPAN  = 2 ** scpd_pkg::BIDX_W;
  localparam int BAND_W   = scpd_pkg::BAND_W;
  localparam int LEVEL_W  = scpd_pkg::LEVEL_W;
  localparam int SUM_W    = scpd_pkg::SUM_W;
  localparam int CNT_W    = scpd_pkg::CNT_W;
  localparam int RATIO_W  = scpd_pkg::RATIO_W;
  localparam int OFFSET_W = scpd_pkg::OFFSET_W;
  localparam int PROD_W   = scpd_pkg::PROD_W;
  localparam int CHAN_W   = scpd_pkg::CHAN_W;
  localparam int N_W      = scpd_pkg::DIV_N_W;
  localparam int D_W      = scpd_pkg::DIV_D_W;

  // Table that folds an incoming band number onto the store depth, built by counting.
  function automatic logic [IN_SPAN*IDX_W-1:0] build_fold();
    logic [IN_SPAN*IDX_W-1:0] tab;
    int                       r;
    tab = '0;
    r   = 0;
    for (int i = 0; i < IN_SPAN; i++) begin
      tab[i*IDX_W +: IDX_W] = IDX_W'(r);
      r = (r == MAX_BANDS - 1) ? 0 : r + 1;
    end
    return tab;
  endfunction

  localparam logic [IN_SPAN*IDX_W-1:0] FOLD = build_fold();

  // Scale one color channel, add the peak offset and saturate.
  function automatic logic [CHAN_W-1:0] chan_sat(input logic [PROD_W-1:0]   prod,
                                                 input logic [OFFSET_W-1:0] ofs);
    logic [OFFSET_W:0] v;
    v = (OFFSET_W + 1)'(prod[PROD_W-1:2]) + (OFFSET_W + 1)'(ofs);
    return (v[OFFSET_W:16] > 9'(scpd_pkg::CHAN_MAX)) ? scpd_pkg::CHAN_MAX : v[23:16];
  endfunction

  logic [BAND_W-1:0]   store [MAX_BANDS];
  logic [BAND_W-1:0]   rdata;
  logic [IDX_W-1:0]    in_idx;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    clr_addr;
  logic [BAND_W-1:0]   incoming_r;
  logic                last_r;
  logic [2*BAND_W-1:0] dec_prod;
  logic [BAND_W-1:0]   dec;
  logic [BAND_W-1:0]   level;
  logic [20:0]         amp_full;
  logic [BAND_W:0]     amp_scaled;
  logic [BAND_W-1:0]   amp_clip;
  logic [BAND_W-1:0]   amp;

  logic [BAND_W-1:0]   running_peak;
  logic [SUM_W-1:0]    useful_sum;
  logic [CNT_W-1:0]    useful_count;
  logic [SUM_W:0]      sum_add;
  logic [BAND_W-1:0]   held_peak;
  logic [BAND_W-1:0]   held_average;

  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  logic [LEVEL_W-1:0]  red_next;
  logic [LEVEL_W-1:0]  green_next;
  logic [LEVEL_W-1:0]  blue_next;

  logic [N_W-1:0]      dividend;
  logic [D_W-1:0]      divisor;
  logic [OFFSET_W-1:0] peak255;
  logic                div_busy;
  logic                div_done;
  logic [N_W-1:0]      quotient;
  logic [RATIO_W-1:0]  ratio;
  logic [OFFSET_W-1:0] offset;
  logic [BAND_W-1:0]   avg;

  logic [PROD_W-1:0]   red_prod;
  logic [PROD_W-1:0]   green_prod;
  logic [PROD_W-1:0]   blue_prod;

  assign in_idx = FOLD[int'(band_index)*IDX_W +: IDX_W];

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r      <= in_idx;
      incoming_r <= band_level;
      last_r     <= last_band;
    end
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Band store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      store[clr_addr] <= '0;
    end else if (cmd.upd) begin
      store[idx_r] <= level;
    end
    if (cmd.accept) begin
      rdata <= store[in_idx];
    end
  end

  // Decay of the stored level.
  assign dec_prod = (2*BAND_W)'(rdata) * (2*BAND_W)'(decay_factor);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dec <= dec_prod[2*BAND_W-1:BAND_W];
    end
  end

  // New level, amplitude scaling by 100 into Q10.6 and clipping.
  always_comb begin
    level      = (incoming_r > dec) ? incoming_r : dec;
    amp_full   = 21'(level) * 21'd25;
    amp_scaled = amp_full[20:4];
    amp_clip   = (amp_scaled > {1'b0, amplitude_limit}) ? amplitude_limit
                                                        : amp_scaled[BAND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      amp <= amp_clip;
    end
  end

  // Frame statistics: peak, useful sum and count, and the values held for next frame.
  assign sum_add = {1'b0, useful_sum} + (SUM_W + 1)'(amp);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
      useful_sum   <= '0;
      useful_count <= '0;
      held_peak    <= '0;
      held_average <= '0;
    end else if (cmd.emit) begin
      held_peak    <= running_peak;
      held_average <= avg;
      running_peak <= '0;
      useful_sum   <= '0;
      useful_count <= '0;
    end else if (cmd.acc) begin
      if (amp > running_peak) begin
        running_peak <= amp;
      end
      if (amp > useful_threshold) begin
        useful_sum <= sum_add[SUM_W] ? scpd_pkg::SUM_MAX : sum_add[SUM_W-1:0];
        if (useful_count != scpd_pkg::COUNT_MAX) begin
          useful_count <= useful_count + CNT_W'(1);
        end
      end
    end
  end

  // Six-phase color wheel step.
  always_comb begin
    red_next   = red_level;
    green_next = green_level;
    blue_next  = blue_level;
    if (red_level >= scpd_pkg::FULL_LEVEL && green_level < scpd_pkg::FULL_LEVEL &&
        blue_level == '0) begin
      green_next = green_level + LEVEL_W'(1);
    end else if (red_level != '0 && green_level >= scpd_pkg::FULL_LEVEL &&
                 blue_level == '0) begin
      red_next = red_level - LEVEL_W'(1);
    end else if (green_level >= scpd_pkg::FULL_LEVEL &&
                 blue_level < scpd_pkg::FULL_LEVEL) begin
      blue_next = blue_level + LEVEL_W'(1);
    end else if (green_level != '0 && blue_level >= scpd_pkg::FULL_LEVEL) begin
      green_next = green_level - LEVEL_W'(1);
    end else if (red_level < scpd_pkg::FULL_LEVEL && green_level == '0 &&
                 blue_level >= scpd_pkg::FULL_LEVEL) begin
      red_next = red_level + LEVEL_W'(1);
    end else if (red_level >= scpd_pkg::FULL_LEVEL && green_level == '0 &&
                 blue_level != '0) begin
      blue_next = blue_level - LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_level   <= scpd_pkg::FULL_LEVEL;
      green_level <= '0;
      blue_level  <= '0;
    end else if (cmd.wheel) begin
      red_level   <= red_next;
      green_level <= green_next;
      blue_level  <= blue_next;
    end
  end

  // Operand selection for the shared divider.
  assign peak255 = {held_peak, 8'b0} - OFFSET_W'(held_peak);

  always_comb begin
    case (cmd.div_op)
      scpd_pkg::DIV_RATIO: begin
        dividend = N_W'({held_average, 18'b0});
        divisor  = amplitude_limit;
      end
      scpd_pkg::DIV_OFFSET: begin
        dividend = {peak255, 16'b0};
        divisor  = amplitude_limit;
      end
      scpd_pkg::DIV_AVG: begin
        dividend = N_W'(useful_sum);
        divisor  = D_W'(useful_count);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  scpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp and keep each quotient. A zero divisor gives all ones: full scale, but avg is 0.
  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_op)
        scpd_pkg::DIV_RATIO: begin
          if (quotient > N_W'(scpd_pkg::RATIO_ONE)) begin
            ratio <= scpd_pkg::RATIO_ONE;
          end else if (quotient < N_W'(scpd_pkg::RATIO_MIN)) begin
            ratio <= scpd_pkg::RATIO_MIN;
          end else begin
            ratio <= quotient[RATIO_W-1:0];
          end
        end
        scpd_pkg::DIV_OFFSET: begin
          offset <= (quotient > N_W'(scpd_pkg::OFFSET_MAX)) ? scpd_pkg::OFFSET_MAX
                                                            : quotient[OFFSET_W-1:0];
        end
        default: begin
          if (useful_count == '0) begin
            avg <= '0;
          end else if (quotient > N_W'(scpd_pkg::AVG_MAX)) begin
            avg <= scpd_pkg::AVG_MAX;
          end else begin
            avg <= quotient[BAND_W-1:0];
          end
        end
      endcase
    end
  end

  // Scale the color levels by the ratio.
  always_ff @(posedge clk) begin
    if (cmd.amp_mul) begin
      red_prod   <= PROD_W'(red_level) * PROD_W'(ratio);
      green_prod <= PROD_W'(green_level) * PROD_W'(ratio);
      blue_prod  <= PROD_W'(blue_level) * PROD_W'(ratio);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_out           <= chan_sat(red_prod, offset);
      green_out         <= chan_sat(green_prod, offset);
      blue_out          <= chan_sat(blue_prod, offset);
      frame_peak_out    <= running_peak;
      frame_average_out <= avg;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.clear_last = (clr_addr == IDX_W'(MAX_BANDS - 1));
    status.last_band  = last_r;
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

  // A result is loaded only into a free output register, and shows next cycle.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting word");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("loaded result not presented");

  // No band enters while the divider is running.
  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !div_busy)
    else $error("band accepted during frame division");

  // The captured ratio stays within 0.1 .. 1.0.
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_capture && cmd.div_op == scpd_pkg::DIV_RATIO) |=>
      (ratio >= scpd_pkg::RATIO_MIN && ratio <= scpd_pkg::RATIO_ONE))
    else $error("ratio out of range");

endmodule

// ----- rtl/core/scpd_ctrl.sv -----
// Controller state machine: band sequencing, clearing pass and end-of-frame steps.
`timescale 1ns / 1ps

module scpd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scpd_pkg::dp_status_t status,
  output scpd_pkg::dp_cmd_t    cmd
);

  scpd_pkg::state_t  state;
  scpd_pkg::state_t  state_next;
  scpd_pkg::div_op_t div_op;
  scpd_pkg::div_op_t div_op_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= scpd_pkg::ST_CLEAR;
      div_op <= scpd_pkg::DIV_RATIO;
    end else begin
      state  <= state_next;
      div_op <= div_op_next;
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    div_op_next = div_op;
    case (state)
      scpd_pkg::ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = scpd_pkg::ST_IDLE;
        end
      end
      scpd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = scpd_pkg::ST_MUL;
        end
      end
      scpd_pkg::ST_MUL: begin
        state_next = scpd_pkg::ST_UPD;
      end
      scpd_pkg::ST_UPD: begin
        state_next = scpd_pkg::ST_ACC;
      end
      scpd_pkg::ST_ACC: begin
        if (status.last_band) begin
          state_next = scpd_pkg::ST_WHEEL;
        end else if (in_valid) begin
          state_next = scpd_pkg::ST_MUL;
        end else begin
          state_next = scpd_pkg::ST_IDLE;
        end
      end
      scpd_pkg::ST_WHEEL: begin
        state_next  = scpd_pkg::ST_DIV_GO;
        div_op_next = scpd_pkg::DIV_RATIO;
      end
      scpd_pkg::ST_DIV_GO: begin
        state_next = scpd_pkg::ST_DIV_WAIT;
      end
      scpd_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          case (div_op)
            scpd_pkg::DIV_RATIO: begin
              div_op_next = scpd_pkg::DIV_OFFSET;
              state_next  = scpd_pkg::ST_DIV_GO;
            end
            scpd_pkg::DIV_OFFSET: begin
              div_op_next = scpd_pkg::DIV_AVG;
              state_next  = scpd_pkg::ST_DIV_GO;
            end
            default: begin
              state_next = scpd_pkg::ST_AMP;
            end
          endcase
        end
      end
      scpd_pkg::ST_AMP: begin
        state_next = scpd_pkg::ST_EMIT;
      end
      scpd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = scpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scpd_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd        = '0;
    cmd.div_op = div_op;
    in_ready   = 1'b0;
    case (state)
      scpd_pkg::ST_CLEAR:    cmd.clear_wr = 1'b1;
      scpd_pkg::ST_IDLE:     in_ready = 1'b1;
      scpd_pkg::ST_MUL:      cmd.mul = 1'b1;
      scpd_pkg::ST_UPD:      cmd.upd = 1'b1;
      scpd_pkg::ST_ACC: begin
        cmd.acc  = 1'b1;
        in_ready = !status.last_band;
      end
      scpd_pkg::ST_WHEEL:    cmd.wheel = 1'b1;
      scpd_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
      scpd_pkg::ST_DIV_WAIT: cmd.div_capture = status.div_done;
      scpd_pkg::ST_AMP:      cmd.amp_mul = 1'b1;
      scpd_pkg::ST_EMIT:     cmd.emit = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.accept = in_valid && in_ready;
  end

endmodule
